// File: rtl/cwcg_pkg.sv
// cwcg_pkg: types, register indexes and address constants of the charger
// write command generator; used by every rtl file of the block but cwcg_if
`timescale 1ns / 1ps
`default_nettype none
package cwcg_pkg;

  typedef enum logic [1:0] {
    KIND_CONNECT    = 2'd0,
    KIND_DISCONNECT = 2'd1,
    KIND_ALLOC      = 2'd2,
    KIND_POLL       = 2'd3
  } kind_e;

  localparam logic [2:0] CFG_MIN_CURRENT = 3'd0;
  localparam logic [2:0] CFG_MAX_CURRENT = 3'd1;
  localparam logic [2:0] CFG_FS_TIMEOUT  = 3'd2;
  localparam logic [2:0] CFG_KEEPALIVE   = 3'd3;
  localparam logic [2:0] CFG_PHASE_SW    = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [15:0] ADDR_SET_CURRENT = 16'd5004;
  localparam logic [15:0] ADDR_ENABLE      = 16'd5014;
  localparam logic [15:0] ADDR_PHASE_SRC   = 16'd5050;
  localparam logic [15:0] ADDR_PHASE_TRIG  = 16'd5052;
  localparam logic [15:0] ADDR_FS_CURRENT  = 16'd5016;
  localparam logic [15:0] ADDR_FS_TIMEOUT  = 16'd5018;
  localparam logic [15:0] PHASE_SRC_MODBUS = 16'd3;

  localparam logic [1:0] ENABLE_UNKNOWN = 2'd3;
  localparam logic [2:0] PHASES_UNKNOWN = 3'd7;
  localparam logic [2:0] PHASES_ONE     = 3'd1;
  localparam logic [2:0] PHASES_THREE   = 3'd3;

  localparam int unsigned NUM_WR = 6;
  localparam int unsigned WR_FS_CUR = 0;
  localparam int unsigned WR_FS_TO  = 1;
  localparam int unsigned WR_PH_SRC = 2;
  localparam int unsigned WR_CUR    = 3;
  localparam int unsigned WR_EN     = 4;
  localparam int unsigned WR_TRIG   = 5;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef struct packed {
    logic [15:0] min_current;
    logic [15:0] max_current;
    logic [9:0]  fs_timeout;
    logic [19:0] keepalive;
    logic        phase_sw_on;
  } cfg_t;

  typedef struct packed {
    logic [NUM_WR-1:0] mask;
    logic [9:0]        fs_timeout;
    logic [15:0]       current;
    logic              en_val;
    logic              trig_val;
  } bundle_t;

endpackage
`default_nettype wire

// File: rtl/cwcg_if.sv
// cwcg_if: valid/ready channel interfaces for event items and register writes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface cwcg_evt_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [15:0]       alloc_current_ma;
  logic signed [7:0] alloc_phases;
  logic [31:0]       now_ms;
  logic              phase_report_valid;
  logic [7:0]        phase_report;

  modport source (output valid, kind, alloc_current_ma, alloc_phases, now_ms,
                  phase_report_valid, phase_report, input ready);
  modport sink (input valid, kind, alloc_current_ma, alloc_phases, now_ms,
                phase_report_valid, phase_report, output ready);
endinterface

interface cwcg_wr_if;
  logic        valid;
  logic        ready;
  logic [15:0] reg_address;
  logic [15:0] reg_data;
  logic        last_write;

  modport source (output valid, reg_address, reg_data, last_write, input ready);
  modport sink (input valid, reg_address, reg_data, last_write, output ready);
endinterface
`default_nettype wire

// File: rtl/charger_write_command_generator_top.sv
// charger_write_command_generator_top: configuration registers and the
// front end, bundle queue and back end; depends on cwcg_pkg, cwcg_if and submodules
`timescale 1ns / 1ps
`default_nettype none
// The front end takes one event item per cycle while the two-entry bundle
// queue has room; connect, disconnect and allocation items finish in that
// cycle. A poll cycle becomes a bundle of zero to six register writes, which
// the back end sends one per cycle from its output register while the write
// channel takes them, through the single write port of the back end. A bundle
// passes the queue, the back end's work register and the output register;
// last_write marks the final write of each poll cycle.
module charger_write_command_generator_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cwcg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [cwcg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  cwcg_evt_if.sink                               evt_i,
  cwcg_wr_if.source                              wr_o
);

  cwcg_pkg::cfg_t    cfg_q;
  cwcg_pkg::bundle_t push_data;
  cwcg_pkg::bundle_t pop_data;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_current <= 16'd6000;
      cfg_q.max_current <= 16'd32000;
      cfg_q.fs_timeout  <= 10'd60;
      cfg_q.keepalive   <= 20'd25000;
      cfg_q.phase_sw_on <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cwcg_pkg::CFG_MIN_CURRENT: cfg_q.min_current <= cfg_data_i[15:0];
        cwcg_pkg::CFG_MAX_CURRENT: cfg_q.max_current <= cfg_data_i[15:0];
        cwcg_pkg::CFG_FS_TIMEOUT:  cfg_q.fs_timeout  <= cfg_data_i[9:0];
        cwcg_pkg::CFG_KEEPALIVE:   cfg_q.keepalive   <= cfg_data_i[19:0];
        cwcg_pkg::CFG_PHASE_SW:    cfg_q.phase_sw_on <= cfg_data_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  cwcg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .evt_i    (evt_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (push_data)
  );

  cwcg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  cwcg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (pop_data),
    .q_pop_o   (q_pop),
    .wr_o      (wr_o)
  );

endmodule
`default_nettype wire

// File: rtl/cwcg_fifo.sv
// cwcg_fifo: short queue of write bundles between front and back end
// depends on cwcg_pkg
`timescale 1ns / 1ps
`default_nettype none
module cwcg_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire cwcg_pkg::bundle_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output cwcg_pkg::bundle_t     pop_data_o,
  output logic                  empty_o
);

  cwcg_pkg::bundle_t                  mem_q [cwcg_pkg::QDEPTH];
  logic [cwcg_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [cwcg_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [cwcg_pkg::QCNT_W-1:0]        count_q, count_d;

  assign full_o     = (count_q == cwcg_pkg::QCNT_W'(cwcg_pkg::QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == cwcg_pkg::QPTR_W'(cwcg_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == cwcg_pkg::QPTR_W'(cwcg_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("bundle queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("bundle queue underflow");

endmodule
`default_nettype wire

// File: rtl/cwcg_front.sv
// cwcg_front: accepts event items, keeps link and sent-value state and
// turns a poll cycle into a bundle of pending writes; depends on cwcg_pkg, cwcg_if
`timescale 1ns / 1ps
`default_nettype none
module cwcg_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cwcg_pkg::cfg_t cfg_i,
  cwcg_evt_if.sink           evt_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output cwcg_pkg::bundle_t  q_data_o
);

  logic              link_up_q, link_up_d;
  logic              fs_done_q, fs_done_d;
  logic              ps_done_q, ps_done_d;
  logic              alloc_seen_q, alloc_seen_d;
  logic [15:0]       want_cur_q, want_cur_d;
  logic signed [7:0] want_ph_q, want_ph_d;
  logic [1:0]        sent_en_q, sent_en_d;
  logic [15:0]       sent_cur_q, sent_cur_d;
  logic [2:0]        sent_ph_q, sent_ph_d;
  logic [31:0]       stamp_q, stamp_d;

  logic              accept;
  logic              enable;
  logic              due;
  logic [31:0]       elapsed;
  logic [15:0]       cur;
  logic [2:0]        target;
  logic [7:0]        reported;
  cwcg_pkg::bundle_t bundle;

  assign evt_i.ready = !q_full_i;
  assign accept      = evt_i.valid && evt_i.ready;

  always_comb begin
    elapsed  = evt_i.now_ms - stamp_q;
    due      = (elapsed >= {12'd0, cfg_i.keepalive});
    enable   = (want_ph_q > 8'sd0) && (want_cur_q >= cfg_i.min_current);
    cur      = (want_cur_q < cfg_i.min_current) ? cfg_i.min_current : want_cur_q;
    if (cur > cfg_i.max_current) begin
      cur = cfg_i.max_current;
    end
    target   = (want_ph_q >= 8'sd3) ? cwcg_pkg::PHASES_THREE : cwcg_pkg::PHASES_ONE;
    reported = evt_i.phase_report_valid ? evt_i.phase_report : {5'd0, target};
  end

  always_comb begin
    link_up_d    = link_up_q;
    fs_done_d    = fs_done_q;
    ps_done_d    = ps_done_q;
    alloc_seen_d = alloc_seen_q;
    want_cur_d   = want_cur_q;
    want_ph_d    = want_ph_q;
    sent_en_d    = sent_en_q;
    sent_cur_d   = sent_cur_q;
    sent_ph_d    = sent_ph_q;
    stamp_d      = stamp_q;
    bundle            = '0;
    bundle.fs_timeout = cfg_i.fs_timeout;
    bundle.current    = cur;
    bundle.trig_val   = (target == cwcg_pkg::PHASES_THREE);
    case (cwcg_pkg::kind_e'(evt_i.kind))
      cwcg_pkg::KIND_CONNECT: begin
        link_up_d  = 1'b1;
        fs_done_d  = 1'b0;
        ps_done_d  = 1'b0;
        sent_en_d  = cwcg_pkg::ENABLE_UNKNOWN;
        sent_cur_d = '0;
        sent_ph_d  = cwcg_pkg::PHASES_UNKNOWN;
        stamp_d    = '0;
      end
      cwcg_pkg::KIND_DISCONNECT: begin
        link_up_d = 1'b0;
      end
      cwcg_pkg::KIND_ALLOC: begin
        alloc_seen_d = 1'b1;
        want_cur_d   = evt_i.alloc_current_ma;
        want_ph_d    = evt_i.alloc_phases;
      end
      cwcg_pkg::KIND_POLL: begin
        if (link_up_q) begin
          if (!fs_done_q) begin
            bundle.mask[cwcg_pkg::WR_FS_CUR] = 1'b1;
            bundle.mask[cwcg_pkg::WR_FS_TO]  = 1'b1;
            fs_done_d = 1'b1;
          end
          if (cfg_i.phase_sw_on && !ps_done_q) begin
            bundle.mask[cwcg_pkg::WR_PH_SRC] = 1'b1;
            ps_done_d = 1'b1;
          end
          if (alloc_seen_q) begin
            if (!enable) begin
              if (sent_en_q != 2'd0 || due) begin
                bundle.mask[cwcg_pkg::WR_EN] = 1'b1;
                bundle.en_val = 1'b0;
                sent_en_d = 2'd0;
                stamp_d   = evt_i.now_ms;
              end
            end else begin
              if (sent_cur_q != cur || due) begin
                bundle.mask[cwcg_pkg::WR_CUR] = 1'b1;
                sent_cur_d = cur;
              end
              if (sent_en_q != 2'd1 || due) begin
                bundle.mask[cwcg_pkg::WR_EN] = 1'b1;
                bundle.en_val = 1'b1;
                sent_en_d = 2'd1;
              end
              if (due) begin
                stamp_d = evt_i.now_ms;
              end
              if (cfg_i.phase_sw_on && ps_done_d) begin
                if ({5'd0, target} != reported && sent_ph_q != target) begin
                  bundle.mask[cwcg_pkg::WR_TRIG] = 1'b1;
                  sent_ph_d = target;
                end else if ({5'd0, target} == reported) begin
                  sent_ph_d = target;
                end
              end
            end
          end
        end
      end
      default: begin
        link_up_d = link_up_q;
      end
    endcase
  end

  assign q_push_o = accept && (|bundle.mask);
  assign q_data_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_up_q    <= 1'b0;
      fs_done_q    <= 1'b0;
      ps_done_q    <= 1'b0;
      alloc_seen_q <= 1'b0;
      want_cur_q   <= '0;
      want_ph_q    <= '0;
      sent_en_q    <= cwcg_pkg::ENABLE_UNKNOWN;
      sent_cur_q   <= '0;
      sent_ph_q    <= cwcg_pkg::PHASES_UNKNOWN;
      stamp_q      <= '0;
    end else if (accept) begin
      link_up_q    <= link_up_d;
      fs_done_q    <= fs_done_d;
      ps_done_q    <= ps_done_d;
      alloc_seen_q <= alloc_seen_d;
      want_cur_q   <= want_cur_d;
      want_ph_q    <= want_ph_d;
      sent_en_q    <= sent_en_d;
      sent_cur_q   <= sent_cur_d;
      sent_ph_q    <= sent_ph_d;
      stamp_q      <= stamp_d;
    end
  end

  a_connect_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && evt_i.kind == cwcg_pkg::KIND_CONNECT) |=>
      (link_up_q && !fs_done_q && !ps_done_q && sent_en_q == cwcg_pkg::ENABLE_UNKNOWN))
    else $error("connect did not re-arm state");

endmodule
`default_nettype wire

// File: rtl/cwcg_back.sv
// cwcg_back: takes bundles from the queue and emits their writes one per
// cycle while the write channel takes them, through an output register; depends on cwcg_pkg, cwcg_if
`timescale 1ns / 1ps
`default_nettype none
module cwcg_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire cwcg_pkg::bundle_t q_data_i,
  output logic               q_pop_o,
  cwcg_wr_if.source          wr_o
);

  logic [cwcg_pkg::NUM_WR-1:0] mask_q, mask_d;
  cwcg_pkg::bundle_t           work_q, work_d;
  logic                        out_valid_q, out_valid_d;
  logic [15:0]                 addr_q, addr_d;
  logic [15:0]                 value_q, value_d;
  logic                        last_q, last_d;

  logic                        out_free;
  logic                        have_work;
  logic                        emit;
  logic [cwcg_pkg::NUM_WR-1:0] pick;
  logic [cwcg_pkg::NUM_WR-1:0] mask_left;
  logic [15:0]                 sel_addr;
  logic [15:0]                 sel_value;

  assign out_free  = !out_valid_q || wr_o.ready;
  assign have_work = |mask_q;
  assign emit      = out_free && have_work;
  assign pick      = mask_q & (~mask_q + 1'b1);
  assign mask_left = mask_q & ~pick;
  assign q_pop_o   = !q_empty_i && (!have_work || (emit && mask_left == '0));

  always_comb begin
    sel_addr  = cwcg_pkg::ADDR_FS_CURRENT;
    sel_value = '0;
    if (pick[cwcg_pkg::WR_FS_TO]) begin
      sel_addr  = cwcg_pkg::ADDR_FS_TIMEOUT;
      sel_value = {6'd0, work_q.fs_timeout};
    end else if (pick[cwcg_pkg::WR_PH_SRC]) begin
      sel_addr  = cwcg_pkg::ADDR_PHASE_SRC;
      sel_value = cwcg_pkg::PHASE_SRC_MODBUS;
    end else if (pick[cwcg_pkg::WR_CUR]) begin
      sel_addr  = cwcg_pkg::ADDR_SET_CURRENT;
      sel_value = work_q.current;
    end else if (pick[cwcg_pkg::WR_EN]) begin
      sel_addr  = cwcg_pkg::ADDR_ENABLE;
      sel_value = {15'd0, work_q.en_val};
    end else if (pick[cwcg_pkg::WR_TRIG]) begin
      sel_addr  = cwcg_pkg::ADDR_PHASE_TRIG;
      sel_value = {15'd0, work_q.trig_val};
    end
  end

  always_comb begin
    mask_d      = mask_q;
    work_d      = work_q;
    out_valid_d = out_valid_q;
    addr_d      = addr_q;
    value_d     = value_q;
    last_d      = last_q;
    if (out_valid_q && wr_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      addr_d      = sel_addr;
      value_d     = sel_value;
      last_d      = (mask_left == '0);
      mask_d      = mask_left;
    end
    if (q_pop_o) begin
      mask_d = q_data_i.mask;
      work_d = q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    addr_q  <= addr_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  assign wr_o.valid       = out_valid_q;
  assign wr_o.reg_address = addr_q;
  assign wr_o.reg_data    = value_q;
  assign wr_o.last_write  = last_q;

  a_addr_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (addr_q == cwcg_pkg::ADDR_FS_CURRENT || addr_q == cwcg_pkg::ADDR_FS_TIMEOUT ||
                     addr_q == cwcg_pkg::ADDR_PHASE_SRC || addr_q == cwcg_pkg::ADDR_SET_CURRENT ||
                     addr_q == cwcg_pkg::ADDR_ENABLE || addr_q == cwcg_pkg::ADDR_PHASE_TRIG))
    else $error("write to unknown register address");

  a_last_ends_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && mask_left == '0) |=> (out_valid_q && last_q))
    else $error("final write of a bundle not marked last");

endmodule
`default_nettype wire
